/* src/assert_macros.svh */
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication.
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* src/rau_pkg.sv */
package rau_pkg;

  localparam int unsigned OperandWidthDef = 16;
  localparam int unsigned NumW = 33;
  localparam int unsigned DenW = 32;
  localparam int unsigned WkW  = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_MUL = 3'd1,
    OP_EQ  = 3'd2,
    OP_INC = 3'd3,
    OP_RED = 3'd4
  } op_e;

  // Start of a shift-add multiply.
  typedef struct packed {
    logic           start;
    logic [WkW-1:0] mcand;
    logic [WkW-1:0] mplier;
  } mul_req_t;

  // Start of a restoring division.
  typedef struct packed {
    logic           start;
    logic [WkW-1:0] dividend;
    logic [WkW-1:0] divisor;
  } div_req_t;

endpackage

/* src/rau_mul.sv */
// Serial multiplier, one multiplier bit a cycle, result modulo 2^64.
module rau_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rau_pkg::mul_req_t req_i,
  output logic              busy_o,
  output logic [63:0]       prod_o
);
  import rau_pkg::*;

  logic [WkW-1:0] acc_q, acc_d, mc_q, mc_d, mp_q, mp_d;
  logic [6:0]     cnt_q, cnt_d;

  always_comb begin
    acc_d = acc_q;
    mc_d  = mc_q;
    mp_d  = mp_q;
    cnt_d = cnt_q;
    if (req_i.start) begin
      acc_d = '0;
      mc_d  = req_i.mcand;
      mp_d  = req_i.mplier;
      cnt_d = 7'(WkW);
    end else if (cnt_q != '0) begin
      if (mp_q[0]) acc_d = acc_q + mc_q;
      mc_d  = {mc_q[WkW-2:0], 1'b0};
      mp_d  = {1'b0, mp_q[WkW-1:1]};
      // stop early once no multiplier bits remain
      cnt_d = (mp_d == '0) ? 7'd0 : cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
  end

  assign busy_o = (cnt_q != '0);
  assign prod_o = acc_q;
endmodule

/* src/rau_div.sv */
// Restoring divider, one quotient bit a cycle over 64 bits.
module rau_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rau_pkg::div_req_t req_i,
  output logic              busy_o,
  output logic [63:0]       quot_o,
  output logic [63:0]       rem_o
);
  import rau_pkg::*;

  logic [WkW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [6:0]     cnt_q, cnt_d;
  logic [WkW:0]   trial;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    trial = '0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.dividend;
      dvs_d = req_i.divisor;
      cnt_d = 7'(WkW);
    end else if (cnt_q != '0) begin
      trial = {rem_q, quo_q[WkW-1]} - {1'b0, dvs_q};
      if (!trial[WkW]) begin
        rem_d = trial[WkW-1:0];
        quo_d = {quo_q[WkW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[WkW-2:0], quo_q[WkW-1]};
        quo_d = {quo_q[WkW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;
  assign rem_o  = rem_q;
endmodule

/* src/rational_arith_unit.sv */
// Fraction arithmetic unit.
// Slave channel s_axis_*: one beat carries an opcode in tuser and two signed
// fractions a = a_num/a_den, b = b_num/b_den in tdata. Opcodes: add, multiply,
// exact compare, increment a, reduce a. Master channel m_axis_*: one beat
// per request with res_num, res_den and is_equal in tdata.
// Operands are sign extended from OPERAND_WIDTH bits. Add and multiply form
// products on a shared bit-serial multiplier: a start step, up to 64 shift
// steps and a hand-back step, fewer shift steps once the multiplier runs out
// of set bits. When numerator and denominator are both at least 1 the result
// is divided by their gcd on a shared restoring divider: a start step, 64
// steps and a hand-back step per division. The Euclid loop costs one division
// per step, then two more divisions finish the reduction.
// Compare and unused opcodes go straight to the output register; increment
// and reduce skip the multiplier. The time a reduction takes grows with the
// number of Euclid steps.
// One request is in flight at a time; s_axis_tready is high only when the
// unit is idle and the output register is empty, so a new request is not
// taken until the last result has been handed on. Reset empties the unit
// and the output register; when m_axis_tready is held low the result
// simply waits.
module rational_arith_unit #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_num, a_den, b_num, b_den (16 bits each, lowest first)
  input  logic [63:0]  s_axis_tdata,
  // req_type
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_num[32:0], res_den[64:33], is_equal[65], zero fill to 72 bits
  output logic [71:0]  m_axis_tdata
);
  import rau_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M1   = 4'd1;
  localparam logic [3:0] S_M2   = 4'd2;
  localparam logic [3:0] S_M3   = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_G    = 4'd5;
  localparam logic [3:0] S_D1   = 4'd6;
  localparam logic [3:0] S_D2   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;
  localparam logic [3:0] S_WM   = 4'd9;
  localparam logic [3:0] S_WD   = 4'd10;

  logic [3:0]     st_q, st_d, ret_q, ret_d;
  logic [2:0]     op_q, op_d;
  logic [WkW-1:0] an_q, ad_q, bn_q, bd_q, an_d, ad_d, bn_d, bd_d;
  logic [WkW-1:0] rn_q, rd_q, rn_d, rd_d, gx_q, gy_q, gx_d, gy_d;
  logic           eq_q, eq_d;
  logic           ov_q, ov_d;
  logic [71:0]    od_q, od_d;
  mul_req_t       mreq;
  div_req_t       dreq;
  logic           mbusy, dbusy;
  logic [WkW-1:0] prod, quot, remd;
  logic           fire_in;

  function automatic logic [63:0] sext(input logic [15:0] v);
    logic [OPERAND_WIDTH-1:0] t;
    t = OPERAND_WIDTH'(v);
    return {{(64-OPERAND_WIDTH){t[OPERAND_WIDTH-1]}}, t};
  endfunction

  function automatic logic pos(input logic [63:0] v);
    return (v != '0) && !v[63];
  endfunction

  rau_mul u_mul (.clk_i, .rst_ni, .req_i(mreq), .busy_o(mbusy), .prod_o(prod));
  rau_div u_div (.clk_i, .rst_ni, .req_i(dreq), .busy_o(dbusy), .quot_o(quot),
                 .rem_o(remd));

  assign s_axis_tready = (st_q == S_IDLE) && !ov_q;
  assign fire_in       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  always_comb begin
    st_d = st_q; ret_d = ret_q; op_d = op_q;
    an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    rn_d = rn_q; rd_d = rd_q; gx_d = gx_q; gy_d = gy_q;
    eq_d = eq_q; od_d = od_q;
    ov_d = ov_q && !m_axis_tready;
    mreq = '0;
    dreq = '0;
    unique case (st_q)
      S_IDLE: begin
        if (fire_in) begin
          op_d = s_axis_tuser;
          an_d = sext(s_axis_tdata[15:0]);
          ad_d = sext(s_axis_tdata[31:16]);
          bn_d = sext(s_axis_tdata[47:32]);
          bd_d = sext(s_axis_tdata[63:48]);
          rn_d = '0; rd_d = '0; eq_d = 1'b0;
          st_d = S_M1;
        end
      end
      S_M1: begin
        unique case (op_q)
          OP_ADD: begin
            mreq = '{start: 1'b1, mcand: an_q, mplier: bd_q};
            ret_d = S_M2; st_d = S_WM;
          end
          OP_MUL: begin
            mreq = '{start: 1'b1, mcand: an_q, mplier: bn_q};
            ret_d = S_M3; st_d = S_WM;
          end
          OP_INC: begin
            rn_d = an_q + ad_q; rd_d = ad_q; st_d = S_CHK;
          end
          OP_RED: begin
            rn_d = an_q; rd_d = ad_q; st_d = S_CHK;
          end
          OP_EQ: begin
            eq_d = (an_q == bn_q) && (ad_q == bd_q); st_d = S_OUT;
          end
          default: st_d = S_OUT;
        endcase
      end
      S_M2: begin
        rn_d = prod;
        mreq = '{start: 1'b1, mcand: bn_q, mplier: ad_q};
        ret_d = S_M3; st_d = S_WM;
      end
      S_M3: begin
        // product from the previous step is the numerator (or its second term)
        rn_d = (op_q == OP_ADD) ? rn_q + prod : prod;
        mreq = '{start: 1'b1, mcand: ad_q, mplier: bd_q};
        ret_d = S_CHK; st_d = S_WM;
      end
      S_CHK: begin
        if (op_q == OP_ADD || op_q == OP_MUL) rd_d = prod;
        if (pos(rn_d) && pos(rd_d)) begin
          gx_d = rn_d; gy_d = rd_d;
          st_d = S_G;
        end else begin
          st_d = S_OUT;
        end
      end
      S_G: begin
        if (gy_q == '0) begin
          dreq = '{start: 1'b1, dividend: rn_q, divisor: gx_q};
          ret_d = S_D1; st_d = S_WD;
        end else begin
          dreq = '{start: 1'b1, dividend: gx_q, divisor: gy_q};
          gx_d = gy_q;
          ret_d = S_G; st_d = S_WD;
        end
      end
      S_D1: begin
        rn_d = quot;
        dreq = '{start: 1'b1, dividend: rd_q, divisor: gx_q};
        ret_d = S_D2; st_d = S_WD;
      end
      S_D2: begin
        rd_d = quot;
        st_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_d) begin
          od_d = {6'd0, eq_q, rd_q[DenW-1:0], rn_q[NumW-1:0]};
          ov_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      S_WM: begin
        if (!mbusy) st_d = ret_q;
      end
      S_WD: begin
        if (!dbusy) begin
          if (ret_q == S_G) gy_d = remd;
          st_d = ret_q;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ret_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ret_q <= ret_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    an_q <= an_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d;
    rn_q <= rn_d; rd_q <= rd_d; gx_q <= gx_d; gy_q <= gy_d;
    eq_q <= eq_d; od_q <= od_d;
  end

`include "assert_macros.svh"
  `RAU_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, s_axis_tready, st_q == S_IDLE)
  `RAU_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata))
  `RAU_ASSERT_IMP(a_not_both_busy, clk_i, rst_ni, mbusy, !dbusy)
endmodule

/* bench/rational_arith_unit_tb.sv */
module rational_arith_unit_tb;
  import rau_pkg::*;

  localparam logic [2:0] OpUnusedLo = 3'd5;
  localparam logic [2:0] OpUnusedHi = 3'd7;
  localparam int unsigned RandomItems = 1600;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] a_num;
    logic signed [15:0] a_den;
    logic signed [15:0] b_num;
    logic signed [15:0] b_den;
  } frac_req_t;

  typedef struct packed {
    logic [32:0] res_num;
    logic [31:0] res_den;
    logic        is_equal;
  } frac_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  frac_req_t   req_q[$];
  frac_res_t   fraction_results_q[$];
  frac_req_t   cur_req;
  int unsigned offered_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned hold_cnt = 0;
  bit          hold_done = 1'b0;

  rational_arith_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic bit pos_val(bit [63:0] v);
    return v != 64'd0 && !v[63];
  endfunction

  function automatic frac_res_t compute_fraction(frac_req_t r);
    bit [63:0] an, ad, bn, bd, rn, rd, x, y, t;
    bit        arith;
    frac_res_t res;
    an = {{48{r.a_num[15]}}, r.a_num};
    ad = {{48{r.a_den[15]}}, r.a_den};
    bn = {{48{r.b_num[15]}}, r.b_num};
    bd = {{48{r.b_den[15]}}, r.b_den};
    rn = '0;
    rd = '0;
    arith = 1'b1;
    res = '0;
    case (r.op)
      OP_ADD: begin
        rn = an * bd + bn * ad;
        rd = ad * bd;
      end
      OP_MUL: begin
        rn = an * bn;
        rd = ad * bd;
      end
      OP_INC: begin
        rn = an + ad;
        rd = ad;
      end
      OP_RED: begin
        rn = an;
        rd = ad;
      end
      OP_EQ: begin
        res.is_equal = (an == bn) && (ad == bd);
        arith = 1'b0;
      end
      default: arith = 1'b0;
    endcase
    if (arith && pos_val(rn) && pos_val(rd)) begin
      x = rn;
      y = rd;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      rn = rn / x;
      rd = rd / x;
    end
    res.res_num = rn[32:0];
    res.res_den = rd[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_cnt++;
  endtask

  function automatic logic signed [15:0] rand_operand();
    if ($urandom_range(99) < 85) return 16'(signed'($urandom_range(200)) - 100);
    return 16'($urandom);
  endfunction

  task automatic add_req(logic [2:0] op, logic signed [15:0] an, logic signed [15:0] ad,
                         logic signed [15:0] bn, logic signed [15:0] bd);
    frac_req_t r;
    r.op = op;
    r.a_num = an;
    r.a_den = ad;
    r.b_num = bn;
    r.b_den = bd;
    req_q.push_back(r);
  endtask

  // driver: new beat once the previous one was taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || accepted_cnt == offered_cnt)) begin
      if (req_q.size() != 0 &&
          ((offered_cnt >= 500 && offered_cnt < 900) || $urandom_range(99) >= 9)) begin
        cur_req = req_q.pop_front();
        offered_cnt++;
        s_axis_tuser  <= cur_req.op;
        s_axis_tdata  <= {cur_req.b_den, cur_req.b_num, cur_req.a_den, cur_req.a_num};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off so the unit backs up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && result_cnt >= 300) begin
        hold_cnt <= 400;
        hold_done <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (result_cnt >= 900 && result_cnt < 1300) || $urandom_range(99) >= 9;
      end
    end
  end

  always @(posedge clk_i) begin
    frac_req_t r;
    frac_res_t got, exp_res;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      r.op = s_axis_tuser;
      {r.b_den, r.b_num, r.a_den, r.a_num} = s_axis_tdata;
      fraction_results_q.push_back(compute_fraction(r));
      accepted_cnt <= accepted_cnt + 1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.res_num  = m_axis_tdata[32:0];
      got.res_den  = m_axis_tdata[64:33];
      got.is_equal = m_axis_tdata[65];
      result_cnt <= result_cnt + 1;
      if (fraction_results_q.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
      end else begin
        exp_res = fraction_results_q.pop_front();
        if (got.res_num !== exp_res.res_num)
          report_mismatch($sformatf("res_num %h, want %h", got.res_num, exp_res.res_num));
        if (got.res_den !== exp_res.res_den)
          report_mismatch($sformatf("res_den %h, want %h", got.res_den, exp_res.res_den));
        if (got.is_equal !== exp_res.is_equal)
          report_mismatch($sformatf("is_equal %b, want %b", got.is_equal, exp_res.is_equal));
      end
    end
  end

  initial begin
    logic [2:0] op;
    logic signed [15:0] an, ad;
    // extremes, every opcode, sign and zero corners
    add_req(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    add_req(OP_ADD, 16'sd1, 16'sd2, -16'sd1, 16'sd2);
    add_req(OP_ADD, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    add_req(OP_ADD, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    add_req(OP_MUL, 16'sd6, 16'sd4, 16'sd2, 16'sd9);
    add_req(OP_MUL, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    add_req(OP_MUL, 16'sd32767, 16'sd1, -16'sd1, 16'sd32767);
    add_req(OP_EQ, 16'sd5, 16'sd7, 16'sd5, 16'sd7);
    add_req(OP_EQ, 16'sd1, 16'sd2, 16'sd2, 16'sd4);
    add_req(OP_EQ, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    add_req(OP_INC, 16'sd3, 16'sd9, 16'sd0, 16'sd0);
    add_req(OP_INC, -16'sd4, 16'sd4, 16'sd1, 16'sd1);
    add_req(OP_INC, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0);
    add_req(OP_RED, 16'sd12, 16'sd18, 16'sd0, 16'sd0);
    add_req(OP_RED, -16'sd12, 16'sd18, 16'sd0, 16'sd0);
    add_req(OP_RED, 16'sd12, -16'sd18, 16'sd0, 16'sd0);
    add_req(OP_RED, 16'sd0, 16'sd5, 16'sd0, 16'sd0);
    add_req(OP_RED, 16'sd7, 16'sd0, 16'sd0, 16'sd0);
    add_req(OP_RED, 16'sd32767, 16'sd1, 16'sd0, 16'sd0);
    add_req(OP_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    add_req(OpUnusedLo, 16'sd3, 16'sd4, 16'sd5, 16'sd6);
    add_req(OpUnusedHi, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
    for (int i = 0; i < RandomItems; i++) begin
      op = ($urandom_range(99) < 4) ? 3'($urandom_range(OpUnusedHi, OpUnusedLo))
                                    : 3'($urandom_range(OP_RED, OP_ADD));
      an = rand_operand();
      ad = rand_operand();
      // compares want a fair share of hits
      if (op == OP_EQ && $urandom_range(1)) add_req(op, an, ad, an, ad);
      else add_req(op, an, ad, rand_operand(), rand_operand());
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (req_q.size() == 0 && accepted_cnt == offered_cnt && fraction_results_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
